// File: rtl/rpks_pkg.sv
// Shared types and constants for the RC pulse kill switch.
package rpks_pkg;

	localparam int unsigned CntW   = 20;
	localparam int unsigned WidthW = 16;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned DataW  = 20;

	localparam logic [CntW-1:0]   CntMax   = '1;
	localparam logic [WidthW-1:0] WidthMax = '1;

	// register indexes of the configuration port
	localparam logic [IdxW-1:0] REG_WIDTH_THRESHOLD = 3'd0;
	localparam logic [IdxW-1:0] REG_SIGNAL_TIMEOUT  = 3'd1;
	localparam logic [IdxW-1:0] REG_STARTUP_HOLD    = 3'd2;
	localparam logic [IdxW-1:0] REG_NORMAL_BLINK    = 3'd3;
	localparam logic [IdxW-1:0] REG_FAILSAFE_BLINK  = 3'd4;

	// reset values of the registers
	localparam logic [WidthW-1:0] RstWidthThreshold = 16'd1500;
	localparam logic [CntW-1:0]   RstSignalTimeout  = 20'd200000;
	localparam logic [CntW-1:0]   RstStartupHold    = 20'd1000000;
	localparam logic [CntW-1:0]   RstNormalBlink    = 20'd1000000;
	localparam logic [CntW-1:0]   RstFailsafeBlink  = 20'd50000;

	typedef enum logic [1:0] {
		PH_HOLD = 2'd0,
		PH_WAIT = 2'd1,
		PH_HIGH = 2'd2,
		PH_FAIL = 2'd3
	} phase_t;

	typedef struct packed {
		logic [WidthW-1:0] width_threshold;
		logic [CntW-1:0]   signal_timeout;
		logic [CntW-1:0]   startup_hold;
		logic [CntW-1:0]   normal_blink;
		logic [CntW-1:0]   failsafe_blink;
	} cfg_t;

	typedef struct packed {
		logic              kill;
		logic              led;
		logic              fail;
		logic              wvalid;
		logic [WidthW-1:0] width;
	} res_t;

	// saturating 20-bit increment
	function automatic logic [CntW-1:0] inc_sat(input logic [CntW-1:0] v);
		return (v == CntMax) ? CntMax : v + 1'b1;
	endfunction

endpackage

// File: rtl/rpks_cfg.sv
// Configuration register file of the RC pulse kill switch.
module rpks_cfg
	import rpks_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IdxW-1:0]  idx,
	input  logic [DataW-1:0] data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_threshold <= RstWidthThreshold;
			cfg_q.signal_timeout  <= RstSignalTimeout;
			cfg_q.startup_hold    <= RstStartupHold;
			cfg_q.normal_blink    <= RstNormalBlink;
			cfg_q.failsafe_blink  <= RstFailsafeBlink;
		end else if (we) begin
			unique case (idx)
				REG_WIDTH_THRESHOLD: cfg_q.width_threshold <= data[WidthW-1:0];
				REG_SIGNAL_TIMEOUT:  cfg_q.signal_timeout  <= data[CntW-1:0];
				REG_STARTUP_HOLD:    cfg_q.startup_hold    <= data[CntW-1:0];
				REG_NORMAL_BLINK:    cfg_q.normal_blink    <= data[CntW-1:0];
				REG_FAILSAFE_BLINK:  cfg_q.failsafe_blink  <= data[CntW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/rpks_core.sv
// Per-tick phase machine, width counter and LED/kill logic.
module rpks_core
	import rpks_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic step,
	input  logic level,
	output res_t res,
	output logic fail
);

	phase_t            phase_q, phase_d;
	logic [CntW-1:0]   pe_q, pe_d;
	logic [WidthW-1:0] wc_q, wc_d;
	logic [WidthW-1:0] lw_q, lw_d;
	logic              kill_q, kill_d;
	logic              led_q, led_d;
	logic [CntW-1:0]   nb_q, nb_d;
	logic [CntW-1:0]   fb_q, fb_d;
	logic              wvalid;

	always_comb begin
		phase_d = phase_q;
		pe_d    = pe_q;
		wc_d    = wc_q;
		lw_d    = lw_q;
		kill_d  = kill_q;
		led_d   = led_q;
		nb_d    = inc_sat(nb_q);
		fb_d    = inc_sat(fb_q);
		wvalid  = 1'b0;

		if (phase_d == PH_HOLD) begin
			if (pe_d >= cfg.startup_hold) begin
				phase_d = PH_WAIT;
				pe_d    = '0;
			end else begin
				pe_d = inc_sat(pe_d);
			end
		end

		if (phase_d == PH_WAIT) begin
			if (level) begin
				phase_d = PH_HIGH;
				wc_d    = WidthW'(1);
				pe_d    = CntW'(1);
			end else begin
				pe_d = inc_sat(pe_d);
			end
			if (pe_d > cfg.signal_timeout)
				phase_d = PH_FAIL;
		end else if (phase_d == PH_HIGH) begin
			if (level) begin
				if (wc_d != WidthMax)
					wc_d = wc_d + 1'b1;
				pe_d = inc_sat(pe_d);
			end else begin
				// falling edge: measurement done
				lw_d   = wc_d;
				wvalid = 1'b1;
				kill_d = !(wc_d > cfg.width_threshold);
				if (nb_d > cfg.normal_blink) begin
					led_d = ~led_d;
					nb_d  = '0;
				end
				phase_d = PH_WAIT;
				pe_d    = CntW'(1);
			end
			if (pe_d > cfg.signal_timeout)
				phase_d = PH_FAIL;
		end

		if (phase_d == PH_FAIL) begin
			kill_d = 1'b1;
			if (fb_d > cfg.failsafe_blink) begin
				led_d = ~led_d;
				fb_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HOLD;
			pe_q    <= '0;
			wc_q    <= '0;
			lw_q    <= '0;
			kill_q  <= 1'b1;
			led_q   <= 1'b1;
			nb_q    <= '0;
			fb_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pe_q    <= pe_d;
			wc_q    <= wc_d;
			lw_q    <= lw_d;
			kill_q  <= kill_d;
			led_q   <= led_d;
			nb_q    <= nb_d;
			fb_q    <= fb_d;
		end
	end

	assign res.kill   = kill_d;
	assign res.led    = led_d;
	assign res.fail   = (phase_d == PH_FAIL);
	assign res.wvalid = wvalid;
	assign res.width  = lw_d;
	assign fail       = (phase_q == PH_FAIL);

endmodule

// File: rtl/rc_pulse_kill_switch.sv
// Top level of the RC pulse kill switch: beat registers, handshake, checks.
// One pin sample beat per microsecond tick is taken into an input register and,
// once the result register has room, judged by the phase logic and written to the
// result register, which drives the outputs. The block takes one beat every cycle
// as long as the result side keeps up; a stalled result holds the input register,
// which then stalls the sample side. Configuration writes land at once and are
// meant for idle time only; unknown indexes are ignored. Failsafe, once latched,
// holds until reset.
module rc_pulse_kill_switch
	import rpks_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IdxW-1:0]   cfg_index,
	input  logic [DataW-1:0]  cfg_data,
	input  logic              pulse_valid,
	output logic              pulse_stall,
	input  logic              pulse_level,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              kill_level,
	output logic              led_level,
	output logic              in_failsafe,
	output logic              width_valid,
	output logic [WidthW-1:0] width_us
);

	cfg_t cfg;
	res_t res;
	res_t res_s2;
	logic valid_s1, level_s1;
	logic out_valid_q;
	logic adv;
	logic fail;

	rpks_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	rpks_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (adv),
		.level  (level_s1),
		.res    (res),
		.fail   (fail)
	);

	assign adv         = valid_s1 && (!out_valid_q || !result_stall);
	assign pulse_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pulse_stall) begin
			valid_s1 <= pulse_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!pulse_stall && pulse_valid)
			level_s1 <= pulse_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign result_valid = out_valid_q;
	assign kill_level   = res_s2.kill;
	assign led_level    = res_s2.led;
	assign in_failsafe  = res_s2.fail;
	assign width_valid  = res_s2.wvalid;
	assign width_us     = res_s2.width;

`ifndef SYNTH
	// failsafe is sticky
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fail |=> fail)
		else $error("failsafe dropped");

	// failsafe always releases the kill pin
	a_fail_release: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && in_failsafe |-> kill_level)
		else $error("kill pulled low in failsafe");

	// a sample beat is only stalled while one is held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_stall |-> valid_s1 && result_valid && result_stall)
		else $error("input stalled without cause");

	// the core only steps when the result register can take the beat
	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result_valid)
		else $error("stepped beat lost");
`endif

endmodule

// File: tb/tb.sv
// Testbench for rc_pulse_kill_switch: directed and random pin beats checked against a local model.
`timescale 1ns / 100ps

module tb
	import rpks_pkg::*;
();

	localparam int unsigned CycleLimit = 3_000_000;
	localparam int unsigned PrintCap   = 40;
	localparam logic [IdxW-1:0] RegSpareLo = REG_FAILSAFE_BLINK + 1'b1;
	localparam logic [IdxW-1:0] RegSpareHi = '1;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic [IdxW-1:0]   cfg_index    = '0;
	logic [DataW-1:0]  cfg_data     = '0;
	logic              pulse_valid  = 1'b0;
	logic              pulse_stall;
	logic              pulse_level  = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic              kill_level;
	logic              led_level;
	logic              in_failsafe;
	logic              width_valid;
	logic [WidthW-1:0] width_us;

	rc_pulse_kill_switch u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pulse_valid  (pulse_valid),
		.pulse_stall  (pulse_stall),
		.pulse_level  (pulse_level),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kill_level   (kill_level),
		.led_level    (led_level),
		.in_failsafe  (in_failsafe),
		.width_valid  (width_valid),
		.width_us     (width_us)
	);

	always #2 clk = ~clk;

	// model copy of the registers
	logic [WidthW-1:0] c_threshold;
	logic [CntW-1:0]   c_timeout;
	logic [CntW-1:0]   c_hold;
	logic [CntW-1:0]   c_nblink;
	logic [CntW-1:0]   c_fblink;

	// model copy of the state
	phase_t            p_phase;
	logic [CntW-1:0]   p_elapsed;
	logic [WidthW-1:0] p_width;
	logic              p_kill;
	logic              p_led;
	logic [CntW-1:0]   p_nblink_cnt;
	logic [CntW-1:0]   p_fblink_cnt;
	logic [WidthW-1:0] p_last_width;

	res_t        expected_ticks[$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned beats_out = 0;
	bit          idle_on = 1'b1;
	int          stall_left = 0;

	initial begin
		c_threshold  = RstWidthThreshold;
		c_timeout    = RstSignalTimeout;
		c_hold       = RstStartupHold;
		c_nblink     = RstNormalBlink;
		c_fblink     = RstFailsafeBlink;
		p_phase      = PH_HOLD;
		p_elapsed    = '0;
		p_width      = '0;
		p_kill       = 1'b1;
		p_led        = 1'b1;
		p_nblink_cnt = '0;
		p_fblink_cnt = '0;
		p_last_width = '0;
	end

	function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// one microsecond tick of the kill switch
	function automatic res_t judge_tick(input logic lvl);
		res_t r;
		logic done;
		done = 1'b0;
		p_nblink_cnt = bump(p_nblink_cnt);
		p_fblink_cnt = bump(p_fblink_cnt);
		if (p_phase == PH_HOLD) begin
			if (p_elapsed >= c_hold) begin
				p_phase   = PH_WAIT;
				p_elapsed = '0;
			end else begin
				p_elapsed = bump(p_elapsed);
			end
		end
		// hold exit falls through: the same tick is judged in wait
		if (p_phase == PH_WAIT) begin
			if (lvl) begin
				p_phase   = PH_HIGH;
				p_width   = 16'd1;
				p_elapsed = 20'd1;
			end else begin
				p_elapsed = bump(p_elapsed);
			end
			if (p_elapsed > c_timeout)
				p_phase = PH_FAIL;
		end else if (p_phase == PH_HIGH) begin
			if (lvl) begin
				if (p_width != '1)
					p_width = p_width + 1'b1;
				p_elapsed = bump(p_elapsed);
			end else begin
				p_last_width = p_width;
				done         = 1'b1;
				p_kill       = !(p_width > c_threshold);
				if (p_nblink_cnt > c_nblink) begin
					p_led        = ~p_led;
					p_nblink_cnt = '0;
				end
				p_phase   = PH_WAIT;
				p_elapsed = 20'd1;
			end
			if (p_elapsed > c_timeout)
				p_phase = PH_FAIL;
		end
		if (p_phase == PH_FAIL) begin
			p_kill = 1'b1;
			if (p_fblink_cnt > c_fblink) begin
				p_led        = ~p_led;
				p_fblink_cnt = '0;
			end
		end
		r.kill   = p_kill;
		r.led    = p_led;
		r.fail   = (p_phase == PH_FAIL);
		r.wvalid = done;
		r.width  = p_last_width;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= PrintCap)
			$display("MISMATCH beat %0d %s: got %0d, expected %0d", beats_out, what, got, want);
	endtask

	// registers change only while the block is idle
	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_WIDTH_THRESHOLD: c_threshold = data[WidthW-1:0];
			REG_SIGNAL_TIMEOUT:  c_timeout   = data[CntW-1:0];
			REG_STARTUP_HOLD:    c_hold      = data[CntW-1:0];
			REG_NORMAL_BLINK:    c_nblink    = data[CntW-1:0];
			REG_FAILSAFE_BLINK:  c_fblink    = data[CntW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(input logic lvl);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			pulse_valid <= 1'b0;
			pulse_level <= 1'($urandom_range(0, 1));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pulse_valid <= 1'b1;
		pulse_level <= lvl;
		@(posedge clk);
		while (pulse_stall) @(posedge clk);
		expected_ticks.push_back(judge_tick(lvl));
	endtask

	task automatic send_pulse(input int high_n, input int low_n);
		repeat (high_n) send_tick(1'b1);
		repeat (low_n) send_tick(1'b0);
	endtask

	task automatic drain_ticks();
		@(negedge clk);
		pulse_valid <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// receiver stall bursts
	always @(negedge clk) begin
		if (!arst_n || !idle_on)
			stall_left = 0;
		else if (stall_left == 0 && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 6);
		else if (stall_left != 0)
			stall_left--;
		result_stall <= (stall_left != 0);
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_ticks.size() == 0) begin
				note_mismatch("result beat with nothing expected", 0, 0);
			end else begin
				want = expected_ticks.pop_front();
				if (kill_level !== want.kill)
					note_mismatch("kill_level", kill_level, want.kill);
				if (led_level !== want.led)
					note_mismatch("led_level", led_level, want.led);
				if (in_failsafe !== want.fail)
					note_mismatch("in_failsafe", in_failsafe, want.fail);
				if (width_valid !== want.wvalid)
					note_mismatch("width_valid", width_valid, want.wvalid);
				if (width_us !== want.width)
					note_mismatch("width_us", width_us, want.width);
			end
			beats_out++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic test_startup_hold();
		int hold;
		hold = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 12);
		write_reg(REG_STARTUP_HOLD, 20'(hold));
		// pin activity inside the hold window must be ignored
		for (int i = 0; i < hold + 2; i++)
			send_tick(1'($urandom_range(0, 1)));
		send_pulse(1, 2);
		send_pulse(2, 1);
	endtask

	// threshold still at its reset value here
	task automatic test_reset_threshold();
		send_pulse(40, 2);
		send_pulse(3, 2);
	endtask

	task automatic test_threshold_extremes();
		drain_ticks();
		write_reg(REG_WIDTH_THRESHOLD, {4'hF, 16'h0000});
		write_reg(REG_NORMAL_BLINK, 20'd1);
		write_reg(REG_STARTUP_HOLD, 20'd1000000);
		write_reg(REG_FAILSAFE_BLINK, 20'd1000000);
		send_pulse(1, 1);
		send_pulse(3, 2);
		drain_ticks();
		write_reg(REG_WIDTH_THRESHOLD, {4'h5, 16'hFFFF});
		send_pulse(1, 1);
		send_pulse(40, 3);
		drain_ticks();
		write_reg(REG_NORMAL_BLINK, 20'd1000000);
		send_pulse(2, 2);
	endtask

	// a steady level of exactly the timeout must not latch
	task automatic test_timeout_boundary();
		int lim;
		lim = $urandom_range(10, 30);
		drain_ticks();
		write_reg(REG_SIGNAL_TIMEOUT, 20'(lim));
		send_pulse(lim, lim);
		send_pulse(1, 1);
	endtask

	task automatic test_random_pulses(input int n_beats);
		int sent, thr, hi, lo;
		for (int set_i = 0; set_i < 7; set_i++) begin
			drain_ticks();
			thr = $urandom_range(0, 40);
			write_reg(REG_WIDTH_THRESHOLD, {4'($urandom), 16'(thr)});
			case ($urandom_range(0, 2))
				0: write_reg(REG_NORMAL_BLINK, 20'd1);
				1: write_reg(REG_NORMAL_BLINK, 20'($urandom_range(2, 300)));
				default: write_reg(REG_NORMAL_BLINK, 20'd1000000);
			endcase
			if ($urandom_range(0, 1) != 0)
				write_reg(REG_SIGNAL_TIMEOUT, 20'd1000000);
			else
				write_reg(REG_SIGNAL_TIMEOUT, 20'($urandom_range(60, 5000)));
			write_reg(REG_FAILSAFE_BLINK, 20'($urandom_range(1, 1000000)));
			write_reg(REG_STARTUP_HOLD, 20'($urandom_range(0, 1000000)));
			write_reg(IdxW'($urandom_range(RegSpareLo, RegSpareHi)), DataW'($urandom));
			sent = 0;
			while (sent < n_beats / 7) begin
				case ($urandom_range(0, 9))
					0: hi = thr;
					1: hi = thr + 1;
					2: hi = 1;
					default: hi = $urandom_range(1, 50);
				endcase
				if (hi < 1)
					hi = 1;
				lo = $urandom_range(1, 8);
				send_pulse(hi, lo);
				sent += hi + lo;
			end
		end
	endtask

	// failsafe holds until reset, so this runs last
	task automatic test_failsafe_latch();
		int mode, lim;
		drain_ticks();
		idle_on = 1'b0;
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_FAILSAFE_BLINK, 20'd1);
		else
			write_reg(REG_FAILSAFE_BLINK, 20'($urandom_range(2, 25)));
		mode = $urandom_range(0, 2);
		if (mode == 0)
			lim = 0;
		else
			lim = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40);
		write_reg(REG_SIGNAL_TIMEOUT, 20'(lim));
		if (mode == 1)
			repeat (lim + 2) send_tick(1'b0);
		else if (mode == 2)
			repeat (lim + 2) send_tick(1'b1);
		repeat (150) send_tick(1'($urandom_range(0, 1)));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_startup_hold();
		test_reset_threshold();
		test_threshold_extremes();
		test_timeout_boundary();
		test_random_pulses(490);
		test_failsafe_latch();
		drain_ticks();
		repeat (8) @(posedge clk);
		if (expected_ticks.size() != 0)
			note_mismatch("expected beats never returned", 0, expected_ticks.size());
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/rpks_pkg.sv
rtl/rpks_cfg.sv
rtl/rpks_core.sv
rtl/rc_pulse_kill_switch.sv
tb/tb.sv
